>>> design/spc_pkg.sv
// Shared constants, types and state codes of the squared correlation unit.
package spc_pkg;

  localparam int MAX_PAIRS   = 16384;
  localparam int SAMPLE_BITS = 16;

  localparam int IN_W    = 16;
  localparam int COUNT_W = 15;
  localparam int SUM_W   = 31;
  localparam int CROSS_W = 46;
  localparam int SQ_W    = 45;
  localparam int PROD_IN_W = 2 * SAMPLE_BITS;

  localparam int FRAC_BITS = 16;
  localparam int Q_W       = FRAC_BITS + 1;
  localparam int BIT_W     = $clog2(Q_W);

  localparam int MUL_W  = 64;
  localparam int HALF_W = MUL_W / 2;
  localparam int PROD_W = 2 * MUL_W;
  localparam int REM_W  = PROD_W + FRAC_BITS;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Totals of one completed set.
  typedef struct packed {
    logic [COUNT_W-1:0] n;
    logic [SUM_W-1:0]   sum_first;
    logic [SUM_W-1:0]   sum_second;
    logic [CROSS_W-1:0] sum_cross;
    logic [SQ_W-1:0]    sum_first_sq;
    logic [SQ_W-1:0]    sum_second_sq;
  } snap_t;

  typedef struct packed {
    logic             start;
    logic [MUL_W-1:0] a;
    logic [MUL_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] product;
  } mul_resp_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_ISSUE,
    B_WAIT,
    B_CHECK,
    B_DIV,
    B_DONE
  } back_state_t;

  // Multiply sequence of the back end.
  typedef enum logic [2:0] {
    OP_COV_A,
    OP_COV_B,
    OP_VX_A,
    OP_VX_B,
    OP_VY_A,
    OP_VY_B,
    OP_NUM,
    OP_DEN
  } op_t;

endpackage

>>> design/spc_pair_if.sv
// Input channel: one sample pair per transaction.
interface spc_pair_if import spc_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [IN_W-1:0] first_sample;
  logic [IN_W-1:0] second_sample;
  logic            last_pair;

  modport source (output valid, first_sample, second_sample, last_pair, input ready);
  modport sink (input valid, first_sample, second_sample, last_pair, output ready);
endinterface

>>> design/spc_result_if.sv
// Output channel: one correlation result per transaction.
interface spc_result_if import spc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [Q_W-1:0]     r_squared;
  logic               undefined_result;
  logic [COUNT_W-1:0] pair_count;

  modport source (output valid, r_squared, undefined_result, pair_count, input ready);
  modport sink (input valid, r_squared, undefined_result, pair_count, output ready);
endinterface

>>> design/spc_front.sv
// Front end: accumulates count and sums, hands a set's totals to the queue.
module spc_front import spc_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  spc_pair_if.sink       pair_in,
  input  logic           queue_full,
  output logic           push,
  output snap_t          snap
);

  logic [COUNT_W-1:0]        pairs_seen, pairs_seen_next;
  logic signed [SUM_W-1:0]   sum_first, sum_first_next;
  logic signed [SUM_W-1:0]   sum_second, sum_second_next;
  logic signed [CROSS_W-1:0] sum_cross, sum_cross_next;
  logic [SQ_W-1:0]           sum_first_sq, sum_first_sq_next;
  logic [SQ_W-1:0]           sum_second_sq, sum_second_sq_next;

  logic signed [SAMPLE_BITS-1:0] x, y;
  logic signed [PROD_IN_W-1:0]   xy, xx, yy;
  logic                          take, accept;

  assign x = pair_in.first_sample[SAMPLE_BITS-1:0];
  assign y = pair_in.second_sample[SAMPLE_BITS-1:0];
  assign xy = x * y;
  assign xx = x * x;
  assign yy = y * y;

  // count saturates; pairs past the limit are dropped
  assign take   = pairs_seen < COUNT_W'(MAX_PAIRS);
  assign accept = pair_in.valid && pair_in.ready;
  assign pair_in.ready = !queue_full;

  always_comb begin
    pairs_seen_next    = pairs_seen;
    sum_first_next     = sum_first;
    sum_second_next    = sum_second;
    sum_cross_next     = sum_cross;
    sum_first_sq_next  = sum_first_sq;
    sum_second_sq_next = sum_second_sq;
    if (take) begin
      pairs_seen_next    = pairs_seen + COUNT_W'(1);
      sum_first_next     = sum_first + SUM_W'(x);
      sum_second_next    = sum_second + SUM_W'(y);
      sum_cross_next     = sum_cross + CROSS_W'(xy);
      // squares are never negative: zero-extend
      sum_first_sq_next  = sum_first_sq + SQ_W'(unsigned'(xx));
      sum_second_sq_next = sum_second_sq + SQ_W'(unsigned'(yy));
    end
  end

  assign push = accept && pair_in.last_pair;
  assign snap = '{n:             pairs_seen_next,
                  sum_first:     sum_first_next,
                  sum_second:    sum_second_next,
                  sum_cross:     sum_cross_next,
                  sum_first_sq:  sum_first_sq_next,
                  sum_second_sq: sum_second_sq_next};

  always_ff @(posedge clk) begin
    if (rst || push) begin
      pairs_seen    <= '0;
      sum_first     <= '0;
      sum_second    <= '0;
      sum_cross     <= '0;
      sum_first_sq  <= '0;
      sum_second_sq <= '0;
    end else if (accept) begin
      pairs_seen    <= pairs_seen_next;
      sum_first     <= sum_first_next;
      sum_second    <= sum_second_next;
      sum_cross     <= sum_cross_next;
      sum_first_sq  <= sum_first_sq_next;
      sum_second_sq <= sum_second_sq_next;
    end
  end

endmodule

>>> design/spc_queue.sv
// Short queue of completed set totals between front and back ends.
module spc_queue import spc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  snap_t push_data,
  input  logic  pop,
  output snap_t head,
  output logic  empty,
  output logic  full
);

  snap_t               entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [QPTR_W:0]     count;

  assign empty = (count == '0);
  assign full  = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + (QPTR_W+1)'(1);
        2'b01:   count <= count - (QPTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

>>> design/spc_mul.sv
// Shared signed 64x64 multiplier built from four 32x32 partial products.
module spc_mul import spc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  mul_req_t  req,
  output mul_resp_t resp
);

  logic              busy, done;
  logic [2:0]        step;
  logic [MUL_W-1:0]  a_mag, b_mag;
  logic              neg;
  logic [MUL_W-1:0]  pp;
  logic [1:0]        pp_sh;
  logic [PROD_W-1:0] acc, acc_add, product;
  logic [HALF_W-1:0] a_half, b_half;

  assign a_half = step[1] ? a_mag[MUL_W-1:HALF_W] : a_mag[HALF_W-1:0];
  assign b_half = step[0] ? b_mag[MUL_W-1:HALF_W] : b_mag[HALF_W-1:0];

  always_comb begin
    case (pp_sh)
      2'd0:    acc_add = PROD_W'(pp);
      2'd1:    acc_add = PROD_W'(pp) << HALF_W;
      2'd2:    acc_add = PROD_W'(pp) << MUL_W;
      default: acc_add = '0;
    endcase
  end

  // step 0..3 multiply, 1..4 accumulate, 5 apply sign
  always_ff @(posedge clk) begin
    if (!busy && req.start) begin
      a_mag <= req.a[MUL_W-1] ? MUL_W'(-req.a) : req.a;
      b_mag <= req.b[MUL_W-1] ? MUL_W'(-req.b) : req.b;
      neg   <= req.a[MUL_W-1] ^ req.b[MUL_W-1];
      acc   <= '0;
    end else if (busy) begin
      if (step < 3'd4) begin
        pp    <= a_half * b_half;
        pp_sh <= {1'b0, step[1]} + {1'b0, step[0]};
      end
      if (step >= 3'd1 && step <= 3'd4) begin
        acc <= acc + acc_add;
      end
      if (step == 3'd5) begin
        product <= neg ? PROD_W'(-acc) : acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (!busy && req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 3'd1;
        if (step == 3'd5) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign resp = '{done: done, product: product};

endmodule

>>> design/spc_back.sv
// Back end: forms covariance and variances, then divides for r squared.
module spc_back import spc_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  snap_t         head,
  input  logic          queue_empty,
  output logic          pop,
  output mul_req_t      mul_req,
  input  mul_resp_t     mul_resp,
  spc_result_if.source  result_out
);

  back_state_t state, state_next;
  op_t         op;
  snap_t       snap;

  logic signed [MUL_W-1:0] p_a, cov, vx, vy;
  logic [PROD_W-1:0]       num;
  logic [REM_W-1:0]        rem, den_sh;
  logic [Q_W-1:0]          quot;
  logic [BIT_W-1:0]        div_bit;
  logic                    flag, var_zero, fits;
  logic signed [MUL_W-1:0] prod_lo;

  assign prod_lo  = mul_resp.product[MUL_W-1:0];
  assign var_zero = (vx <= 0) || (vy <= 0);
  assign fits     = den_sh <= rem;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE:  if (!queue_empty) state_next = B_ISSUE;
      B_ISSUE: state_next = B_WAIT;
      B_WAIT: begin
        if (mul_resp.done) begin
          if (op == OP_VY_B)      state_next = B_CHECK;
          else if (op == OP_DEN)  state_next = B_DIV;
          else                    state_next = B_ISSUE;
        end
      end
      B_CHECK: state_next = var_zero ? B_DONE : B_ISSUE;
      B_DIV:   if (div_bit == '0) state_next = B_DONE;
      B_DONE:  if (result_out.ready) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop           = (state == B_IDLE) && !queue_empty;
    mul_req.start = (state == B_ISSUE);
    case (op)
      OP_COV_A: begin
        mul_req.a = MUL_W'(snap.n);
        mul_req.b = MUL_W'($signed(snap.sum_cross));
      end
      OP_COV_B: begin
        mul_req.a = MUL_W'($signed(snap.sum_first));
        mul_req.b = MUL_W'($signed(snap.sum_second));
      end
      OP_VX_A: begin
        mul_req.a = MUL_W'(snap.n);
        mul_req.b = MUL_W'(snap.sum_first_sq);
      end
      OP_VX_B: begin
        mul_req.a = MUL_W'($signed(snap.sum_first));
        mul_req.b = MUL_W'($signed(snap.sum_first));
      end
      OP_VY_A: begin
        mul_req.a = MUL_W'(snap.n);
        mul_req.b = MUL_W'(snap.sum_second_sq);
      end
      OP_VY_B: begin
        mul_req.a = MUL_W'($signed(snap.sum_second));
        mul_req.b = MUL_W'($signed(snap.sum_second));
      end
      OP_NUM: begin
        mul_req.a = cov;
        mul_req.b = cov;
      end
      OP_DEN: begin
        mul_req.a = vx;
        mul_req.b = vy;
      end
      default: begin
        mul_req.a = '0;
        mul_req.b = '0;
      end
    endcase
    result_out.valid            = (state == B_DONE);
    result_out.r_squared        = quot;
    result_out.undefined_result = flag;
    result_out.pair_count       = snap.n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (!queue_empty) begin
          snap <= head;
          op   <= OP_COV_A;
          flag <= 1'b0;
          quot <= '0;
        end
      end
      B_WAIT: begin
        if (mul_resp.done) begin
          case (op)
            OP_COV_A, OP_VX_A, OP_VY_A: p_a <= prod_lo;
            OP_COV_B: cov <= p_a - prod_lo;
            OP_VX_B:  vx  <= p_a - prod_lo;
            OP_VY_B:  vy  <= p_a - prod_lo;
            OP_NUM:   num <= mul_resp.product;
            default:  p_a <= p_a;
          endcase
          if (op == OP_DEN) begin
            rem     <= {num, FRAC_BITS'(0)};
            den_sh  <= REM_W'(mul_resp.product) << FRAC_BITS;
            div_bit <= BIT_W'(Q_W - 1);
          end else if (op != OP_VY_B) begin
            op <= op_t'(op + 3'd1);
          end
        end
      end
      B_CHECK: begin
        if (var_zero) begin
          flag <= 1'b1;
        end else begin
          op <= OP_NUM;
        end
      end
      B_DIV: begin
        if (fits) begin
          rem           <= rem - den_sh;
          quot[div_bit] <= 1'b1;
        end
        den_sh  <= den_sh >> 1;
        div_bit <= div_bit - BIT_W'(1);
      end
      default: begin
        snap <= snap;
      end
    endcase
  end

endmodule

>>> design/squared_pearson_correlation_unit.sv
// Top level of the squared Pearson correlation unit.
//
// Streams signed sample pairs (x, y) and, on each pair marked last, returns
// r^2 = (n*Sxy - Sx*Sy)^2 / ((n*Sxx - Sx^2) * (n*Syy - Sy^2)) as unsigned
// Q1.16, truncated, together with the pair count of the set. When either
// variance term is zero (a set of one pair included) undefined_result is set
// and r_squared is 0. Pairs beyond 16384 in one set are dropped from the
// sums; a last mark on such a pair still closes the set.
//
// Rate: the accumulator takes one pair per cycle. A closed set's totals go
// into a two-entry queue; the back end then works each set through up to
// eight passes of one shared 64x64 multiplier (four 32x32 partial
// products a pass) and a restoring division, dropping the last two passes
// and the division when a variance is zero. Input stalls only while the
// queue holds two sets. Results wait in the back end's output stage until
// taken, while the front end keeps accumulating.
module squared_pearson_correlation_unit import spc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  spc_pair_if.sink     pair_in,
  spc_result_if.source result_out
);

  logic      push, pop, queue_empty, queue_full;
  snap_t     snap_in, snap_head;
  mul_req_t  mul_req;
  mul_resp_t mul_resp;

  // accumulate pairs, emit totals on last mark
  spc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .pair_in    (pair_in),
    .queue_full (queue_full),
    .push       (push),
    .snap       (snap_in)
  );

  // decouples the streaming front from the slow back end
  spc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (snap_in),
    .pop       (pop),
    .head      (snap_head),
    .empty     (queue_empty),
    .full      (queue_full)
  );

  spc_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .req  (mul_req),
    .resp (mul_resp)
  );

  spc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (snap_head),
    .queue_empty (queue_empty),
    .pop         (pop),
    .mul_req     (mul_req),
    .mul_resp    (mul_resp),
    .result_out  (result_out)
  );

  // a result always covers at least one pair
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    result_out.valid |-> result_out.pair_count != '0)
    else $error("result with zero pair count");

  // undefined results carry a zero ratio
  a_undef_zero: assert property (@(posedge clk) disable iff (rst)
    result_out.valid && result_out.undefined_result |-> result_out.r_squared == '0)
    else $error("undefined result with nonzero r_squared");

  // r^2 never exceeds one
  a_ratio_range: assert property (@(posedge clk) disable iff (rst)
    result_out.valid |-> result_out.r_squared <= Q_W'(1 << FRAC_BITS))
    else $error("r_squared above one");

  // a closed set is never lost to a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !queue_full)
    else $error("set totals pushed into full queue");

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the squared Pearson correlation unit.
`timescale 1ns / 1ps

module tb_top;
  import spc_pkg::*;

  // Cycles with no transaction on either channel before the run is declared hung.
  // The limit leaves a wide margin over the back end's time per set, for long receiver
  // stalls with two sets queued.
  localparam int WATCHDOG_LIMIT = 4000;
  // Quiet cycles after the last expected result, to catch stray extra results.
  localparam int TAIL_CYCLES    = 300;
  // Keep the log short if the block is badly broken.
  localparam int REPORT_LIMIT   = 60;
  localparam int RANDOM_PHASE_PAIRS = 375;

  // One expected result transaction.
  typedef struct packed {
    logic [Q_W-1:0]     r_sq;
    logic               undefined;
    logic [COUNT_W-1:0] count;
  } corr_result_t;

  logic clk;
  logic rst;

  spc_pair_if   pair_ch ();
  spc_result_if res_ch ();

  squared_pearson_correlation_unit dut (
    .clk        (clk),
    .rst        (rst),
    .pair_in    (pair_ch.sink),
    .result_out (res_ch.source)
  );

  // Idle / stall probabilities in percent, changed per test phase.
  int unsigned src_idle_pct;
  int unsigned sink_stall_pct;

  int unsigned  mismatches;
  int unsigned  stall_cycles;
  corr_result_t pending_r2[$];

  // Running totals of the set being accumulated, at the block's widths.
  logic [COUNT_W-1:0]        pairs_kept;
  logic signed [SUM_W-1:0]   tot_x;
  logic signed [SUM_W-1:0]   tot_y;
  logic signed [CROSS_W-1:0] tot_xy;
  logic signed [SQ_W-1:0]    tot_xx;
  logic signed [SQ_W-1:0]    tot_yy;

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Correlation predictor
  // ---------------------------------------------------------------------------
  function automatic void clear_totals();
    pairs_kept = '0;
    tot_x      = '0;
    tot_y      = '0;
    tot_xy     = '0;
    tot_xx     = '0;
    tot_yy     = '0;
  endfunction

  // Folds one accepted pair into the totals; on a last mark queues the r^2
  // that the block must return and starts a fresh set.
  function automatic void accumulate_pair(input logic [IN_W-1:0] x_raw,
                                          input logic [IN_W-1:0] y_raw,
                                          input logic last);
    logic signed [SAMPLE_BITS-1:0] xs;
    logic signed [SAMPLE_BITS-1:0] ys;
    longint       x, y, n, cov, vx, vy;
    logic [63:0]  cov_mag;
    logic [159:0] num_w, den_w, quo_w;
    corr_result_t res;
    xs = x_raw[SAMPLE_BITS-1:0];
    ys = y_raw[SAMPLE_BITS-1:0];
    x  = longint'(xs);
    y  = longint'(ys);
    // Pairs past the limit are dropped; the count saturates.
    if (pairs_kept < MAX_PAIRS) begin
      pairs_kept = pairs_kept + 1'b1;
      tot_x  = tot_x + SUM_W'(x);
      tot_y  = tot_y + SUM_W'(y);
      tot_xy = tot_xy + CROSS_W'(x * y);
      tot_xx = tot_xx + SQ_W'(x * x);
      tot_yy = tot_yy + SQ_W'(y * y);
    end
    if (last) begin
      n   = longint'(pairs_kept);
      cov = n * longint'(tot_xy) - longint'(tot_x) * longint'(tot_y);
      vx  = n * longint'(tot_xx) - longint'(tot_x) * longint'(tot_x);
      vy  = n * longint'(tot_yy) - longint'(tot_y) * longint'(tot_y);
      res.count = pairs_kept;
      if (vx <= 0 || vy <= 0) begin
        res.undefined = 1'b1;
        res.r_sq      = '0;
      end else begin
        // Exact wide arithmetic: cov^2 <= vx*vy, so the quotient fits Q1.16.
        cov_mag = (cov < 0) ? -cov : cov;
        num_w   = 160'(cov_mag);
        num_w   = num_w * num_w;
        den_w   = 160'(vx) * 160'(vy);
        quo_w   = (num_w << FRAC_BITS) / den_w;
        res.undefined = 1'b0;
        res.r_sq      = quo_w[Q_W-1:0];
      end
      pending_r2.push_back(res);
      clear_totals();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Pair sender: entered and left at a falling edge
  // ---------------------------------------------------------------------------
  task automatic send_pair(input logic [IN_W-1:0] x, input logic [IN_W-1:0] y,
                           input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      pair_ch.valid <= 1'b0;
      @(negedge clk);
    end
    // valid stays high across back-to-back pairs, never dropped and re-raised
    pair_ch.valid         <= 1'b1;
    pair_ch.first_sample  <= x;
    pair_ch.second_sample <= y;
    pair_ch.last_pair     <= last;
    @(posedge clk);
    while (!pair_ch.ready) @(posedge clk);
    accumulate_pair(x, y, last);
    @(negedge clk);
  endtask

  // Sender holds off until every queued result has come back.
  task automatic wait_results_drained();
    pair_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending_r2.size() != 0) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random back-pressure, sampled at the rising edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    res_ch.ready <= !rst && ($urandom_range(99) >= sink_stall_pct);
  end

  function automatic void check_field(input string name, input longint want,
                                      input longint got);
    if (want != got) begin
      if (mismatches < REPORT_LIMIT)
        $display("%0t: %s mismatch: expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    corr_result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_r2.size() == 0) begin
        if (mismatches < REPORT_LIMIT)
          $display({"%0t: unexpected result: expected none actual ",
                    "r_squared %0d undefined %0d count %0d"},
                   $time, res_ch.r_squared, res_ch.undefined_result, res_ch.pair_count);
        mismatches++;
      end else begin
        want = pending_r2.pop_front();
        check_field("r_squared", want.r_sq, res_ch.r_squared);
        check_field("undefined_result", want.undefined, res_ch.undefined_result);
        check_field("pair_count", want.count, res_ch.pair_count);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: no transaction on either side for too long means a hang
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (pair_ch.valid && pair_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired with %0d results outstanding", $time, pending_r2.size());
      $display("FAIL squared_pearson_correlation_unit");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Single pair, constant x, constant y and all-zero sets: variance zero.
  task automatic test_zero_variance();
    send_pair(16'sd100, 16'sd200, 1'b1);
    send_pair(16'sd5, 16'sd1, 1'b0);
    send_pair(16'sd5, 16'sd2, 1'b0);
    send_pair(16'sd5, 16'sd3, 1'b1);
    send_pair(16'sd1, -16'sd7, 1'b0);
    send_pair(16'sd2, -16'sd7, 1'b1);
    send_pair(16'sd0, 16'sd0, 1'b0);
    send_pair(16'sd0, 16'sd0, 1'b1);
  endtask

  // Exact +1 and -1 correlation give full scale, a symmetric set gives zero.
  task automatic test_perfect_correlation();
    for (int i = 1; i <= 4; i++)
      send_pair(IN_W'(i * 1000), IN_W'(i * 2000), i == 4);
    for (int i = 1; i <= 4; i++)
      send_pair(IN_W'(i * 1000), IN_W'(-i * 3000), i == 4);
    send_pair(16'sd1, 16'sd1, 1'b0);
    send_pair(-16'sd1, 16'sd1, 1'b0);
    send_pair(16'sd1, -16'sd1, 1'b0);
    send_pair(-16'sd1, -16'sd1, 1'b1);
  endtask

  // Full-scale samples of both signs.
  task automatic test_extreme_samples();
    send_pair(16'h8000, 16'h7fff, 1'b0);
    send_pair(16'h7fff, 16'h8000, 1'b0);
    send_pair(16'h8000, 16'h8000, 1'b0);
    send_pair(16'h7fff, 16'h7fff, 1'b0);
    send_pair(16'h0000, 16'hffff, 1'b1);
  endtask

  function automatic int clamp_sample(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // One random set; returns the number of pairs sent.
  task automatic send_random_set(output int unsigned sent);
    int unsigned len, mode, pick;
    int k, noise, x, y, cx;
    pick = $urandom_range(99);
    if (pick < 5)       len = 1;
    else if (pick < 80) len = $urandom_range(2, 16);
    else if (pick < 97) len = $urandom_range(17, 64);
    else                len = $urandom_range(65, 300);
    mode  = $urandom_range(4);
    k     = int'($urandom_range(8)) - 4;
    noise = 1 << $urandom_range(12);
    cx    = int'($urandom_range(65535)) - 32768;
    for (int unsigned i = 0; i < len; i++) begin
      case (mode)
        0: begin
          x = int'($urandom_range(65535)) - 32768;
          y = int'($urandom_range(65535)) - 32768;
        end
        1: begin
          // linear trend plus noise: r^2 spread over the whole range
          x = int'($urandom_range(8000)) - 4000;
          y = clamp_sample(x * k + int'($urandom_range(noise)) - noise / 2);
        end
        2: begin
          x = cx;
          y = int'($urandom_range(65535)) - 32768;
        end
        3: begin
          x = int'($urandom_range(7)) - 4;
          y = int'($urandom_range(7)) - 4;
        end
        default: begin
          x = $urandom_range(1) ? -32768 : 32767;
          y = $urandom_range(2) == 0 ? 0 : ($urandom_range(1) ? -32768 : 32767);
        end
      endcase
      // randomly swap roles so the constant case hits y as well
      if ($urandom_range(1)) send_pair(IN_W'(x), IN_W'(y), i == len - 1);
      else                   send_pair(IN_W'(y), IN_W'(x), i == len - 1);
    end
    sent = len;
  endtask

  // Random sets under four flow-control regimes, draining between regimes.
  task automatic test_random_sets();
    int unsigned sent, total;
    int unsigned idle_tab [4] = '{0, 68, 0, 19};
    int unsigned stall_tab[4] = '{0, 0, 68, 19};
    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct   = idle_tab[ph];
      sink_stall_pct = stall_tab[ph];
      total = 0;
      while (total < RANDOM_PHASE_PAIRS) begin
        send_random_set(sent);
        total += sent;
      end
      wait_results_drained();
    end
  endtask

  task automatic finish_run();
    wait_results_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("PASS squared_pearson_correlation_unit");
    end else begin
      $display("FAIL squared_pearson_correlation_unit");
    end
    $finish;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst                   = 1'b1;
    pair_ch.valid         = 1'b0;
    pair_ch.first_sample  = '0;
    pair_ch.second_sample = '0;
    pair_ch.last_pair     = 1'b0;
    res_ch.ready          = 1'b0;
    src_idle_pct          = 0;
    sink_stall_pct        = 0;
    mismatches            = 0;
    stall_cycles          = 0;
    clear_totals();
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    test_zero_variance();
    test_perfect_correlation();
    test_extreme_samples();
    // sender holds off here until the directed results are all back
    wait_results_drained();
    test_random_sets();
    finish_run();
  end

endmodule
